// File: hdl/pfr_pkg.sv
// Shared types and constants for the page framebuffer refresh block.
`default_nettype none

package pfr_pkg;

    // Default panel geometry
    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;

    // Panel command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // Slot numbers within one page of the refresh stream
    localparam int SLOT_PAGE_CMD  = 0;
    localparam int SLOT_COL_LOW   = 1;
    localparam int SLOT_COL_HIGH  = 2;
    localparam int SLOT_DATA_BASE = 3;

    // Input beat kind
    typedef enum logic {
        MODE_DRAW    = 1'b0,
        MODE_ADVANCE = 1'b1
    } mode_t;

    // Refresh stream beat description from the sequencer
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       is_data;
        logic       frame_end;
    } refresh_info_t;

endpackage

`default_nettype wire

// File: hdl/pfr_store.sv
// Frame store memory with a one-pass clear sweep after reset.
`default_nettype none

module pfr_store
    import pfr_pkg::*;
#(
    parameter int DEPTH  = PANEL_WIDTH_DEF * ((PANEL_HEIGHT_DEF + 7) / 8),
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    output logic                   clr_busy
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;

    // clear sweep: one entry per cycle
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we = clr_busy_reg | wr_en;
    assign mem_wa = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wd = clr_busy_reg ? 8'h00 : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// File: hdl/pfr_seq.sv
// Refresh stream sequencer: page and slot counters, command bytes, data address.
`default_nettype none

module pfr_seq
    import pfr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int ADDR_W       = $clog2(PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8))
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    output refresh_info_t          info,
    output logic [ADDR_W-1:0]      rd_addr
);

    localparam int PAGES  = (PANEL_HEIGHT + 7) / 8;
    localparam int SLOTS  = PANEL_WIDTH + SLOT_DATA_BASE;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [SLOT_W-1:0] col;
    logic [ADDR_W-1:0] page_base;

    always_comb begin
        slot_next = slot_reg;
        page_next = page_reg;
        if (step) begin
            if (slot_reg == SLOT_W'(SLOTS - 1)) begin
                slot_next = '0;
                page_next = (page_reg == PAGE_W'(PAGES - 1)) ? '0 : page_reg + 1'b1;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            page_reg <= '0;
        end else begin
            slot_reg <= slot_next;
            page_reg <= page_next;
        end
    end

    // data address; meaningless on command slots, where it is not used
    assign col       = slot_reg - SLOT_W'(SLOT_DATA_BASE);
    assign page_base = ADDR_W'(ADDR_W'(page_reg) * ADDR_W'(PANEL_WIDTH));
    assign rd_addr   = page_base + ADDR_W'(col);

    always_comb begin
        info.cmd_byte  = CMD_COL_HIGH;
        info.is_data   = 1'b1;
        info.frame_end = 1'b0;
        priority if (slot_reg == SLOT_W'(SLOT_PAGE_CMD)) begin
            info.cmd_byte = CMD_PAGE_BASE + 8'(page_reg);
            info.is_data  = 1'b0;
        end else if (slot_reg == SLOT_W'(SLOT_COL_LOW)) begin
            info.cmd_byte = CMD_COL_LOW;
            info.is_data  = 1'b0;
        end else if (slot_reg == SLOT_W'(SLOT_COL_HIGH)) begin
            info.cmd_byte = CMD_COL_HIGH;
            info.is_data  = 1'b0;
        end else begin
            info.frame_end = (slot_reg == SLOT_W'(SLOTS - 1)) &&
                             (page_reg == PAGE_W'(PAGES - 1));
        end
    end

endmodule

`default_nettype wire

// File: hdl/page_framebuffer_refresh.sv
// Top level: monochrome page-organized frame store with refresh stream output.
`default_nettype none

// Frame store for a PANEL_WIDTH x PANEL_HEIGHT monochrome panel, one byte per
// column per 8-row page. A draw beat (s_tuser = 0) sets or clears one pixel;
// beats with a column or row outside the panel are dropped and give no output.
// An advance beat (s_tuser = 1) produces one output beat: per page the page
// command (0xB0 + page), column-low 0x00, column-high 0x10, then the page's
// bytes in column order; m_tuser marks display data, m_tlast the last data
// byte of the last page, and the stream wraps after it. The block takes one
// beat per cycle unless stage 1 holds an advance the output cannot take; a
// pixel update is a read-modify-write over two stages of a simple dual-port
// store (read in the accept cycle, write in the next) with a one-deep bypass,
// so back-to-back draws to the same byte are safe. An advance beat passes
// stage 1 and the output register, waiting there while the receiver stalls.
// After reset a sweep clears all PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) entries
// (1024 at the default size), during which s_tready stays low.
module page_framebuffer_refresh
    import pfr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,   // 16 .. 128
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF   // 8 .. 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] color, rest 0
    input  wire logic        s_tuser,   // [0] mode: 0 draw, 1 advance
    // refresh stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tuser,   // [0] is_data
    output logic             m_tlast    // frame_end
);

    localparam int PAGES  = (PANEL_HEIGHT + 7) / 8;
    localparam int DEPTH  = PANEL_WIDTH * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    // input fields
    mode_t      in_mode;
    logic [7:0] in_x;
    logic [7:0] in_y;
    logic       in_color;

    assign in_mode  = mode_t'(s_tuser);
    assign in_x     = s_tdata[7:0];
    assign in_y     = s_tdata[15:8];
    assign in_color = s_tdata[16];

    // stage 1 (store data arrives here)
    logic              s1_valid_reg;
    mode_t             s1_mode_reg;
    logic              s1_wen_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_mask_reg;
    logic              s1_color_reg;
    refresh_info_t     s1_info_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_data_reg;

    // output register
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic              m_user_reg;
    logic              m_last_reg;

    logic              s_beat;
    logic              s1_move;
    logic              in_range;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] seq_addr;
    refresh_info_t     seq_info;
    logic [7:0]        rd_data;
    logic [7:0]        cur_byte;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              clr_busy;

    // stage 1 frees up unless it holds an advance that cannot leave
    assign s1_move  = !s1_valid_reg || (s1_mode_reg == MODE_DRAW) ||
                      !m_valid_reg || m_tready;
    assign s_tready = !clr_busy && s1_move;
    assign s_beat   = s_tvalid && s_tready;

    // draw address: column + page * width
    assign in_range  = ({1'b0, in_x} < 9'(PANEL_WIDTH)) &&
                       ({1'b0, in_y} < 9'(PANEL_HEIGHT));
    assign draw_addr = ADDR_W'(ADDR_W'(in_y[7:3]) * ADDR_W'(PANEL_WIDTH)) +
                       ADDR_W'(in_x);
    assign rd_addr   = (in_mode == MODE_ADVANCE) ? seq_addr : draw_addr;

    pfr_seq #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_beat && (in_mode == MODE_ADVANCE)),
        .info    (seq_info),
        .rd_addr (seq_addr)
    );

    pfr_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_beat),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (s1_addr_reg),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (s_beat) begin
            s1_valid_reg <= 1'b1;
            // the draw in stage 1 writes on the same edge this read happens
            fwd_reg      <= wr_en && (s1_addr_reg == rd_addr);
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            s1_mode_reg  <= in_mode;
            s1_wen_reg   <= (in_mode == MODE_DRAW) && in_range;
            s1_addr_reg  <= draw_addr;
            s1_mask_reg  <= 8'd1 << in_y[2:0];
            s1_color_reg <= in_color;
            s1_info_reg  <= seq_info;
            fwd_data_reg <= wr_data;
        end
    end

    // read-modify-write of the pixel byte
    assign cur_byte = fwd_reg ? fwd_data_reg : rd_data;
    assign wr_en    = s1_valid_reg && s1_wen_reg;
    assign wr_data  = s1_color_reg ? (cur_byte | s1_mask_reg)
                                   : (cur_byte & ~s1_mask_reg);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && (s1_mode_reg == MODE_ADVANCE) && s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && (s1_mode_reg == MODE_ADVANCE) && s1_move) begin
            m_byte_reg <= s1_info_reg.is_data ? cur_byte : s1_info_reg.cmd_byte;
            m_user_reg <= s1_info_reg.is_data;
            m_last_reg <= s1_info_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: verif/page_framebuffer_refresh_checker.sv
// Scoreboard for page_framebuffer_refresh: shadow frame store, stream predictor, compare.
`default_nettype none

module page_framebuffer_refresh_checker
    import pfr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [16] color
    input  wire logic        s_tuser,   // [0] mode
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] out_byte
    input  wire logic        m_tuser,   // [0] is_data
    input  wire logic        m_tlast,   // frame_end
    output int               mismatch_count,
    output int               stream_pending
);

    localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
    localparam int PAGE_SLOTS = PANEL_WIDTH + SLOT_DATA_BASE;

    logic [7:0]    shadow_store [PANEL_WIDTH * PAGE_COUNT];
    int            scan_page;
    int            scan_slot;
    refresh_info_t expected_stream [$];

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // off-panel pixels are dropped
    task automatic apply_pixel(input logic [7:0] px, input logic [7:0] py, input logic lit);
        int addr;
        if (px < PANEL_WIDTH && py < PANEL_HEIGHT) begin
            addr = int'(px) + (int'(py) / 8) * PANEL_WIDTH;
            shadow_store[addr][py[2:0]] = lit;
        end
    endtask

    task automatic advance_stream(output refresh_info_t beat);
        beat = '0;
        case (scan_slot)
            SLOT_PAGE_CMD: beat.cmd_byte = CMD_PAGE_BASE + 8'(scan_page);
            SLOT_COL_LOW:  beat.cmd_byte = CMD_COL_LOW;
            SLOT_COL_HIGH: beat.cmd_byte = CMD_COL_HIGH;
            default: begin
                beat.cmd_byte  = shadow_store[scan_page * PANEL_WIDTH + scan_slot - SLOT_DATA_BASE];
                beat.is_data   = 1'b1;
                beat.frame_end = (scan_slot == PAGE_SLOTS - 1) && (scan_page == PAGE_COUNT - 1);
            end
        endcase
        if (scan_slot == PAGE_SLOTS - 1) begin
            scan_slot = 0;
            scan_page = (scan_page == PAGE_COUNT - 1) ? 0 : scan_page + 1;
        end else begin
            scan_slot++;
        end
    endtask

    always @(posedge aclk) begin : watch
        refresh_info_t want;
        refresh_info_t beat;
        if (!aresetn) begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
            scan_page = 0;
            scan_slot = 0;
            expected_stream.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_stream.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat %02h", m_tdata));
                end else begin
                    want = expected_stream.pop_front();
                    if (m_tdata !== want.cmd_byte)
                        flag_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.cmd_byte));
                    if (m_tuser !== want.is_data)
                        flag_mismatch($sformatf("is_data %b, want %b", m_tuser, want.is_data));
                    if (m_tlast !== want.frame_end)
                        flag_mismatch($sformatf("frame_end %b, want %b", m_tlast, want.frame_end));
                end
            end
            if (s_tvalid && s_tready) begin
                if (mode_t'(s_tuser) == MODE_ADVANCE) begin
                    advance_stream(beat);
                    expected_stream.push_back(beat);
                end else begin
                    apply_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[16]);
                end
            end
        end
        stream_pending = expected_stream.size();
    end

endmodule

`default_nettype wire

// File: verif/page_framebuffer_refresh_test.sv
// Testbench top for page_framebuffer_refresh: clock, reset, stimulus, back-pressure, verdict.
`default_nettype none

module page_framebuffer_refresh_test
    import pfr_pkg::*;
();

    // Geometry as the block is built here (package defaults)
    localparam int PAGE_COUNT  = (PANEL_HEIGHT_DEF + 7) / 8;
    localparam int PAGE_SLOTS  = PANEL_WIDTH_DEF + SLOT_DATA_BASE;
    localparam int FRAME_BEATS = PAGE_COUNT * PAGE_SLOTS;   // 1048 beats per full refresh

    // Each random phase runs until this many advance beats went in; with the
    // draws mixed in, four phases come to roughly 700 input beats in total.
    localparam int PHASE_ADVANCES   = 120;
    localparam int LONG_HOLD_CYCLES = 400;     // receiver hold-off in the pressure stretch
    localparam int DRAIN_CYCLES     = 20;      // output lags input by stage 1 and the output register
    localparam int RUN_LIMIT_CYCLES = 200000;  // clear sweep + ~700 beats, stalls, many times over

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] pixel_x, [15:8] pixel_y, [16] color, rest 0
    logic        s_tuser;    // [0] mode: 0 draw, 1 advance
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] out_byte
    logic        m_tuser;    // [0] is_data
    logic        m_tlast;    // frame_end

    int          mismatch_count;
    int          stream_pending;

    // Flow-control knobs, set per phase by the stimulus process
    int          src_idle_pct;
    int          sink_stall_pct;
    logic        long_hold_req;
    int          adv_sent;   // advance beats accepted so far; steers draws near the scan

    always #5 aclk = ~aclk;

    page_framebuffer_refresh DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    page_framebuffer_refresh_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .stream_pending (stream_pending)
    );

    // Offer one beat. Inputs move on the falling edge only; the handshake is
    // sampled at the rising edge. Random idle cycles go in front of the beat,
    // and tvalid stays high from one beat to the next when no gap is drawn.
    task automatic send_beat(input mode_t kind, input logic [7:0] px, input logic [7:0] py,
                             input logic lit);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {7'd0, lit, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == MODE_ADVANCE) adv_sent++;
        @(negedge aclk);
    endtask

    // Random traffic: mostly advances (the stream is the observable side), the
    // rest draws. Draws split between the page being scanned now or next, so
    // fresh pixels get read back soon, anywhere on the panel, and raw 8-bit
    // coordinates that often fall off the panel. Advance beats carry junk
    // coordinates, which the block must ignore.
    task automatic send_random_beat();
        logic [7:0] px;
        logic [7:0] py;
        logic       lit;
        int         pick;
        int         focus_page;
        px   = 8'($urandom);
        py   = 8'($urandom);
        lit  = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_beat(MODE_ADVANCE, px, py, lit);
        end else begin
            if (pick >= 90) begin
                px = 8'($urandom_range(PANEL_WIDTH_DEF - 1));
                py = 8'($urandom_range(PANEL_HEIGHT_DEF - 1));
            end else if (pick >= 78) begin
                focus_page = ((adv_sent % FRAME_BEATS) / PAGE_SLOTS + $urandom_range(1))
                             % PAGE_COUNT;
                px = 8'($urandom_range(PANEL_WIDTH_DEF - 1));
                py = 8'(focus_page * 8 + $urandom_range(7));
            end
            // lean toward lit pixels so data bytes fill up
            lit = ($urandom_range(3) != 0);
            send_beat(MODE_DRAW, px, py, lit);
        end
    endtask

    // Receiver: random stalls per phase, plus one long hold-off counted here so
    // the block's output fills and it has to drop s_tready.
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin : stimulus
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = MODE_DRAW;
        s_tdata        = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        long_hold_req  = 1'b0;
        adv_sent       = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: panel corners, off-panel column and row (just past the edge
        // and all ones), clear after set, back-to-back writes to one byte, then
        // enough advances to see the three page commands and the first columns.
        // s_tready stays low through the clearing sweep; send_beat waits it out.
        send_beat(MODE_DRAW, 8'd0,   8'd0,   1'b1);
        send_beat(MODE_DRAW, 8'd127, 8'd63,  1'b1);
        send_beat(MODE_DRAW, 8'd127, 8'd0,   1'b1);
        send_beat(MODE_DRAW, 8'd0,   8'd63,  1'b1);
        send_beat(MODE_DRAW, 8'd128, 8'd0,   1'b1);   // column off panel
        send_beat(MODE_DRAW, 8'd2,   8'd64,  1'b1);   // row off panel
        send_beat(MODE_DRAW, 8'd255, 8'd255, 1'b1);   // both off panel
        send_beat(MODE_DRAW, 8'd0,   8'd0,   1'b0);   // darken the corner again
        send_beat(MODE_DRAW, 8'd0,   8'd7,   1'b1);
        send_beat(MODE_DRAW, 8'd1,   8'd0,   1'b1);
        send_beat(MODE_DRAW, 8'd1,   8'd0,   1'b0);   // same byte, next cycle
        send_beat(MODE_DRAW, 8'd1,   8'd5,   1'b1);
        send_beat(MODE_DRAW, 8'd2,   8'd3,   1'b1);
        repeat (6) send_beat(MODE_ADVANCE, 8'hFF, 8'hFF, 1'b1);

        // Random phases: free-running (with the long receiver hold-off at its
        // start), sender gaps, receiver stalls, then light idling on both sides.
        for (int phase = 0; phase < 4; phase++) begin
            int adv_start;
            case (phase)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    long_hold_req  = 1'b1;
                end
                1: begin
                    src_idle_pct   = 50;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 50;
                end
                default: begin
                    src_idle_pct   = 8;
                    sink_stall_pct = 8;
                end
            endcase
            adv_start = adv_sent;
            while (adv_sent - adv_start < PHASE_ADVANCES) send_random_beat();
        end
        s_tvalid = 1'b0;

        // Let the stream drain, then give stray beats time to show up
        while (stream_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && stream_pending == 0) begin
            $display("PASS page_framebuffer_refresh");
        end else begin
            $display("FAIL page_framebuffer_refresh");
        end
        $finish;
    end

    // Watchdog: covers a hung handshake or expectations that never drain
    initial begin : watchdog
        repeat (RUN_LIMIT_CYCLES) @(posedge aclk);
        $display("FAIL page_framebuffer_refresh");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/pfr_pkg.sv
hdl/pfr_store.sv
hdl/pfr_seq.sv
hdl/page_framebuffer_refresh.sv
verif/page_framebuffer_refresh_checker.sv
verif/page_framebuffer_refresh_test.sv
